>>> hdl/pixel_component_format_converter_top_macros.svh
// assertion helpers for the converter top module
`ifndef PIXEL_COMPONENT_FORMAT_CONVERTER_TOP_MACROS_SVH
`define PIXEL_COMPONENT_FORMAT_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pfc_pkg.sv
package pfc_pkg;

    // stored element formats
    typedef enum logic [2:0] {
        ET_U8   = 3'd0,
        ET_S8   = 3'd1,
        ET_U16  = 3'd2,
        ET_S16  = 3'd3,
        ET_U32  = 3'd4,
        ET_S32  = 3'd5,
        ET_HALF = 3'd6,
        ET_F32  = 3'd7
    } t_elem;

    // configuration register indexes
    localparam logic [1:0] CFG_ELEM  = 2'd0;
    localparam logic [1:0] CFG_NORM  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // transaction modes
    localparam logic MODE_UNPACK = 1'b0;
    localparam logic MODE_PACK   = 1'b1;

    localparam logic [31:0] ONE_BITS = 32'h3f80_0000;

    // finishing operation done in the second lane stage
    typedef enum logic [1:0] {
        FIN_DIRECT   = 2'd0,
        FIN_INT2F    = 2'd1,
        FIN_REP      = 2'd2,
        FIN_NORMPACK = 2'd3
    } t_fin;

    // per-lane control shared by all lanes
    typedef struct packed {
        t_elem elem;
        logic  norm;
        logic  mode;
    } t_lane_ctl;

    // lane stage-one register
    typedef struct packed {
        t_fin        fin;
        t_elem       elem;
        logic        sign;
        logic [63:0] word;
        logic [5:0]  lz;
        logic [7:0]  exp;
    } t_lane_s1;

    typedef struct packed {
        logic        mode;
        logic [31:0] raw_in_0;
        logic [31:0] raw_in_1;
        logic [31:0] raw_in_2;
        logic [31:0] raw_in_3;
        logic [31:0] float_in_0;
        logic [31:0] float_in_1;
        logic [31:0] float_in_2;
        logic [31:0] float_in_3;
    } t_in;

    typedef struct packed {
        logic [31:0] float_out_0;
        logic [31:0] float_out_1;
        logic [31:0] float_out_2;
        logic [31:0] float_out_3;
        logic [31:0] raw_out_0;
        logic [31:0] raw_out_1;
        logic [31:0] raw_out_2;
        logic [31:0] raw_out_3;
        logic        format_error;
    } t_out;

endpackage

>>> hdl/pfc_lane.sv
module pfc_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  pfc_pkg::t_lane_ctl   i_ctl,
    input  logic [31:0]          i_raw,
    input  logic [31:0]          i_flt,
    output logic [31:0]          o_res
);

    // leading zero count, 32 when empty
    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [5:0] c;
        c = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) c = 6'(31 - i);
        end
        return c;
    endfunction

    // half to single, exact
    function automatic logic [31:0] h2f(input logic [15:0] h);
        logic [31:0] s;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [5:0]  k;
        logic [10:0] mm;
        s = {h[15], 31'b0};
        e = h[14:10];
        m = h[9:0];
        k = lzc32({m, 22'b0}) + 6'd1;
        mm = {1'b0, m} << k[3:0];
        if (e == 5'd31) return s | 32'h7f80_0000 | {9'b0, m, 13'b0};
        if (e == 5'd0) begin
            if (m == 10'd0) return s;
            return s | {1'b0, 8'(8'd113 - {2'b0, k}), mm[9:0], 13'b0};
        end
        return s | {1'b0, 8'({3'b0, e} + 8'd112), m, 13'b0};
    endfunction

    // single to half, round to nearest even
    function automatic logic [15:0] f2h(input logic [31:0] f);
        logic [15:0] s;
        logic [7:0]  e;
        logic [22:0] m;
        logic [9:0]  mt;
        logic signed [9:0] eh;
        logic [23:0] mf;
        logic [4:0]  sh;
        logic [15:0] h;
        logic [23:0] rem;
        logic [23:0] hv;
        s = {f[31], 15'b0};
        e = f[30:23];
        m = f[22:0];
        mt = m[22:13];
        eh = 10'(signed'({2'b0, e})) - 10'sd112;
        mf = {1'b1, m};
        sh = 5'(10'sd14 - eh);
        if (e == 8'd255) begin
            if (m == 23'd0) return s | 16'h7c00;
            return s | 16'h7c00 | {6'b0, mt} | {15'b0, (mt == 10'd0)};
        end
        if (eh >= 10'sd31) return s | 16'h7c00;
        if (eh <= 10'sd0) begin
            if (eh < -10'sd10) return s;
            h   = 16'(mf >> sh);
            rem = mf & ((24'd1 << sh) - 24'd1);
            hv  = 24'd1 << (sh - 5'd1);
        end else begin
            h   = {1'b0, eh[4:0], m[22:13]};
            rem = {11'b0, m[12:0]};
            hv  = 24'h1000;
        end
        if (rem > hv || (rem == hv && h[0])) h = h + 16'd1;
        return s | h;
    endfunction

    pfc_pkg::t_lane_s1 n_s1;
    pfc_pkg::t_lane_s1 r_s1;

    logic [31:0] w_v;
    logic        w_neg;
    logic [31:0] w_mag;
    logic [15:0] w_d;
    logic [15:0] w_mask;
    logic        w_sgnd;
    logic [63:0] w_rep;
    logic        w_fs;
    logic [7:0]  w_fe;
    logic [23:0] w_m24;
    logic        w_fnan;
    logic [55:0] w_tsh;
    logic [31:0] w_int;
    logic        w_big;
    logic [31:0] w_hi;
    logic [31:0] w_lom;
    logic [31:0] w_imask;
    logic [31:0] w_plain;

    // decode stored component
    always_comb begin
        case (i_ctl.elem)
            pfc_pkg::ET_U8: begin
                w_v = {24'b0, i_raw[7:0]}; w_neg = 1'b0; w_mag = w_v;
                w_d = 16'd255; w_mask = 16'h00ff; w_sgnd = 1'b0;
                w_rep = {8{i_raw[7:0]}};
                w_hi = 32'd255; w_lom = 32'd0; w_imask = 32'h0000_00ff;
            end
            pfc_pkg::ET_S8: begin
                w_v = {24'b0, i_raw[7:0]}; w_neg = i_raw[7];
                w_mag = w_neg ? {24'b0, 8'(~i_raw[7:0] + 8'd1)} : w_v;
                w_d = 16'd127; w_mask = 16'h00ff; w_sgnd = 1'b1;
                w_rep = {{9{w_mag[6:0]}}, 1'b0};
                w_hi = 32'd127; w_lom = 32'd128; w_imask = 32'h0000_00ff;
            end
            pfc_pkg::ET_U16: begin
                w_v = {16'b0, i_raw[15:0]}; w_neg = 1'b0; w_mag = w_v;
                w_d = 16'd65535; w_mask = 16'hffff; w_sgnd = 1'b0;
                w_rep = {4{i_raw[15:0]}};
                w_hi = 32'd65535; w_lom = 32'd0; w_imask = 32'h0000_ffff;
            end
            pfc_pkg::ET_S16: begin
                w_v = {16'b0, i_raw[15:0]}; w_neg = i_raw[15];
                w_mag = w_neg ? {16'b0, 16'(~i_raw[15:0] + 16'd1)} : w_v;
                w_d = 16'd32767; w_mask = 16'hffff; w_sgnd = 1'b1;
                w_rep = {{4{w_mag[14:0]}}, 4'b0};
                w_hi = 32'd32767; w_lom = 32'd32768; w_imask = 32'h0000_ffff;
            end
            pfc_pkg::ET_S32: begin
                w_v = i_raw; w_neg = i_raw[31];
                w_mag = w_neg ? (~i_raw + 32'd1) : i_raw;
                w_d = 16'd32767; w_mask = 16'hffff; w_sgnd = 1'b1;
                w_rep = 64'd0;
                w_hi = 32'h7fff_ffff; w_lom = 32'h8000_0000; w_imask = 32'hffff_ffff;
            end
            default: begin
                w_v = i_raw; w_neg = 1'b0; w_mag = i_raw;
                w_d = 16'd65535; w_mask = 16'hffff; w_sgnd = 1'b0;
                w_rep = 64'd0;
                w_hi = 32'hffff_ffff; w_lom = 32'd0; w_imask = 32'hffff_ffff;
            end
        endcase
    end

    // float field decode and plain integer saturation
    always_comb begin
        w_fs   = i_flt[31];
        w_fe   = i_flt[30:23];
        w_m24  = {(w_fe != 8'd0), i_flt[22:0]};
        w_fnan = (w_fe == 8'd255) && (i_flt[22:0] != 23'd0);
        w_big  = (w_fe > 8'd158);
        w_tsh  = {32'b0, w_m24} << 5'(w_fe - 8'd127);
        w_int  = (w_fe < 8'd127) ? 32'd0 : w_tsh[54:23];
        if (w_fnan) begin
            w_plain = 32'd0;
        end else if (!w_sgnd) begin
            w_plain = w_fs ? 32'd0 : ((w_big || w_int > w_hi) ? w_hi : w_int);
        end else if (!w_fs) begin
            w_plain = (w_big || w_int > w_hi) ? w_hi : w_int;
        end else if (w_big || w_int > w_lom) begin
            w_plain = w_lom & w_imask;
        end else begin
            w_plain = (32'd0 - w_int) & w_imask;
        end
    end

    // stage one: pick the finishing operation
    always_comb begin
        n_s1      = '0;
        n_s1.fin  = pfc_pkg::FIN_DIRECT;
        n_s1.elem = i_ctl.elem;
        if (i_ctl.mode == pfc_pkg::MODE_UNPACK) begin
            if (i_ctl.elem == pfc_pkg::ET_F32) begin
                n_s1.word = {32'b0, i_raw};
            end else if (i_ctl.elem == pfc_pkg::ET_HALF) begin
                n_s1.word = {32'b0, h2f(i_raw[15:0])};
            end else if (w_mag == 32'd0) begin
                n_s1.word = 64'd0;
            end else if (i_ctl.norm) begin
                if (w_mag[15:0] == w_d) begin
                    n_s1.word = {32'b0, pfc_pkg::ONE_BITS | {w_neg, 31'b0}};
                end else if (w_mag[16:0] > {1'b0, w_d}) begin
                    n_s1.word = {32'b0, pfc_pkg::ONE_BITS | 32'h8000_0000};
                end else begin
                    n_s1.fin  = pfc_pkg::FIN_REP;
                    n_s1.sign = w_neg;
                    n_s1.word = w_rep;
                    n_s1.lz   = lzc32({w_rep[63:48], 16'b0});
                end
            end else begin
                n_s1.fin  = pfc_pkg::FIN_INT2F;
                n_s1.sign = w_neg;
                n_s1.word = {32'b0, w_mag};
                n_s1.lz   = lzc32(w_mag);
            end
        end else begin
            if (i_ctl.elem == pfc_pkg::ET_F32) begin
                n_s1.word = {32'b0, i_flt};
            end else if (i_ctl.elem == pfc_pkg::ET_HALF) begin
                n_s1.word = {48'b0, f2h(i_flt)};
            end else if (i_ctl.norm) begin
                if (w_fnan || (w_fs && !w_sgnd) || w_fe == 8'd0) begin
                    n_s1.word = 64'd0;
                end else if (w_fe >= 8'd127) begin
                    n_s1.word = {48'b0, (w_fs ? (16'd0 - w_d) : w_d) & w_mask};
                end else begin
                    n_s1.fin  = pfc_pkg::FIN_NORMPACK;
                    n_s1.sign = w_fs;
                    n_s1.exp  = w_fe;
                    n_s1.word = {24'b0, 40'(w_m24 * w_d)};
                end
            end else begin
                n_s1.word = {32'b0, w_plain};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_s1 <= n_s1;
    end

    logic [4:0]  s_n;
    logic [15:0] s_mask;
    logic [39:0] s_p;
    logic [4:0]  s_sh;
    logic [24:0] s_q;
    logic [39:0] s_rem;
    logic [39:0] s_hv;
    logic [24:0] s_qr;
    logic [40:0] s_v;
    logic [7:0]  s_rs;
    logic [15:0] s_pm;
    logic [31:0] s_in;
    logic [7:0]  s_irem;
    logic [31:0] s_ibits;
    logic [63:0] s_rp;
    logic [31:0] s_rbits;

    // stage two: normalize, round and finish
    always_comb begin
        case (r_s1.elem)
            pfc_pkg::ET_U8:  begin s_n = 5'd8;  s_mask = 16'h00ff; end
            pfc_pkg::ET_S8:  begin s_n = 5'd7;  s_mask = 16'h00ff; end
            pfc_pkg::ET_U16: begin s_n = 5'd16; s_mask = 16'hffff; end
            default:         begin s_n = 5'd15; s_mask = 16'hffff; end
        endcase
        s_p   = r_s1.word[39:0];
        s_sh  = s_p[6'(s_n) + 6'd23] ? s_n : (s_n - 5'd1);
        s_q   = 25'(s_p >> s_sh);
        s_rem = s_p & ((40'd1 << s_sh) - 40'd1);
        s_hv  = 40'd1 << (s_sh - 5'd1);
        s_qr  = s_q + {24'b0, (s_rem > s_hv || (s_rem == s_hv && s_q[0]))};
        s_v   = {16'b0, s_qr} << s_sh;
        s_rs  = 8'd150 - r_s1.exp;
        s_pm  = (s_rs > 8'd40) ? 16'd0 : 16'(s_v >> s_rs);
        if (r_s1.sign) s_pm = (16'd0 - s_pm) & s_mask;

        s_in   = r_s1.word[31:0] << r_s1.lz[4:0];
        s_irem = s_in[7:0];
        s_ibits = {r_s1.sign, 8'(8'd157 - {2'b0, r_s1.lz}), 23'b0}
                  + {8'b0, s_in[31:8]}
                  + {31'b0, (s_irem > 8'd128 || (s_irem == 8'd128 && s_in[8]))};
        s_ibits[31] = r_s1.sign;

        s_rp    = r_s1.word << r_s1.lz[4:0];
        s_rbits = {r_s1.sign, 8'(8'd126 - {2'b0, r_s1.lz}), s_rp[62:40]}
                  + {31'b0, s_rp[39]};

        case (r_s1.fin)
            pfc_pkg::FIN_INT2F:    o_res = s_ibits;
            pfc_pkg::FIN_REP:      o_res = s_rbits;
            pfc_pkg::FIN_NORMPACK: o_res = {16'b0, s_pm};
            default:               o_res = r_s1.word[31:0];
        endcase
    end

endmodule

>>> hdl/pixel_component_format_converter_top.sv
// Pixel component format converter.
// Input channel i_valid/o_stall carries one pixel per transaction: a mode bit
// (unpack stored components to floats, or pack floats to stored codes), four
// raw components and four float components. Output channel o_valid/i_stall
// returns one result transaction per input: four floats, four raw codes and
// a format error flag. Configuration (element type, normalized flag,
// component count) is written through i_cfg_valid/o_cfg_ready; the user
// must write only while idle (not enforced); the port is always ready.
// Each component goes through its own two-stage lane: stage one decodes and
// counts leading zeros or multiplies by the scale, stage two rounds and
// normalizes; the merge stage applies component count and defaults.
// An accepted input is registered in r_v1 and then in r_v2, which drives
// o_valid; one pixel is accepted every cycle while o_stall is low.
// When the receiver stalls, the result holds and the pipeline keeps
// filling its empty stage, then raises o_stall.
// Synchronous active-low reset empties the pipeline and loads element type
// u8, normalized on and four components.
`include "pixel_component_format_converter_top_macros.svh"

module pixel_component_format_converter_top #(
    parameter int MAX_COMPONENTS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  pfc_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output pfc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [2:0]    i_cfg_data
);

    pfc_pkg::t_elem r_elem;
    logic           r_norm;
    logic [2:0]     r_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem  <= pfc_pkg::ET_U8;
            r_norm  <= 1'b1;
            r_count <= 3'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pfc_pkg::CFG_ELEM:  r_elem  <= pfc_pkg::t_elem'(i_cfg_data);
                pfc_pkg::CFG_NORM:  r_norm  <= i_cfg_data[0];
                pfc_pkg::CFG_COUNT: r_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_v1;
    logic r_v2;
    logic r_mode1;
    logic w_rdy1;
    logic w_rdy2;

    assign w_rdy2  = !r_v2 || !i_stall;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_mode1 <= i_in.mode;
    end

    // component lanes
    pfc_pkg::t_lane_ctl w_ctl;
    logic [31:0] w_raw [4];
    logic [31:0] w_flt [4];
    logic [31:0] w_res [4];

    assign w_ctl.elem = r_elem;
    assign w_ctl.norm = r_norm;
    assign w_ctl.mode = i_in.mode;
    assign w_raw[0] = i_in.raw_in_0;
    assign w_raw[1] = i_in.raw_in_1;
    assign w_raw[2] = i_in.raw_in_2;
    assign w_raw[3] = i_in.raw_in_3;
    assign w_flt[0] = i_in.float_in_0;
    assign w_flt[1] = i_in.float_in_1;
    assign w_flt[2] = i_in.float_in_2;
    assign w_flt[3] = i_in.float_in_3;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        if (g < MAX_COMPONENTS) begin : g_on
            pfc_lane u_lane (
                .i_clk (i_clk),
                .i_en  (w_rdy1),
                .i_ctl (w_ctl),
                .i_raw (w_raw[g]),
                .i_flt (w_flt[g]),
                .o_res (w_res[g])
            );
        end else begin : g_off
            assign w_res[g] = 32'd0;
        end
    end

    // merge lanes with count, defaults and format error
    localparam logic [2:0] MaxC = 3'(MAX_COMPONENTS);
    logic [2:0]    w_n;
    logic          w_err;
    logic [31:0]   w_fo [4];
    logic [31:0]   w_ro [4];
    pfc_pkg::t_out n_out;
    pfc_pkg::t_out r_out;

    always_comb begin
        w_n   = (r_count > MaxC) ? MaxC : r_count;
        w_err = r_norm && (r_elem >= pfc_pkg::ET_U32);
        for (int i = 0; i < 4; i++) begin
            w_fo[i] = 32'd0;
            w_ro[i] = 32'd0;
            if (!w_err) begin
                if (3'(i) < w_n) begin
                    if (r_mode1 == pfc_pkg::MODE_PACK) w_ro[i] = w_res[i];
                    else                                w_fo[i] = w_res[i];
                end else if (i == 3 && r_mode1 == pfc_pkg::MODE_UNPACK) begin
                    w_fo[i] = pfc_pkg::ONE_BITS;
                end
            end
        end
        n_out.float_out_0  = w_fo[0];
        n_out.float_out_1  = w_fo[1];
        n_out.float_out_2  = w_fo[2];
        n_out.float_out_3  = w_fo[3];
        n_out.raw_out_0    = w_ro[0];
        n_out.raw_out_1    = w_ro[1];
        n_out.raw_out_2    = w_ro[2];
        n_out.raw_out_3    = w_ro[3];
        n_out.format_error = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) r_out <= n_out;
    end

    assign o_out = r_out;

    // checks
    `PFC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_out.format_error,
        o_out.raw_out_0 == 32'd0 && o_out.float_out_3 == 32'd0,
        "format error with nonzero payload")
    `PFC_ASSERT_NOW(a_pack_no_float, i_clk, i_rst_n, o_valid && o_out.raw_out_0 != 32'd0,
        o_out.float_out_0 == 32'd0 && o_out.float_out_3 == 32'd0,
        "pack transaction carries float results")
    `PFC_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_v1 && !w_rdy2,
        r_v1 && $stable(r_mode1), "stage one lost a blocked transaction")

endmodule

>>> sim/tb_pixel_component_format_converter_top.sv
`timescale 1ns / 1ps

module tb_pixel_component_format_converter_top;

    localparam logic [31:0] NEG_ONE_BITS = 32'hbf80_0000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD_AT = 320;
    localparam int LONG_HOLD_LEN = 80;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    pfc_pkg::t_in  i_in = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    pfc_pkg::t_out o_out;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [2:0]    i_cfg_data = '0;

    pixel_component_format_converter_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the configuration
    pfc_pkg::t_elem cvt_elem = pfc_pkg::ET_U8;
    logic           cvt_norm = 1'b1;
    logic [2:0]     cvt_count = 3'd4;

    pfc_pkg::t_in  pixel_queue[$];
    pfc_pkg::t_out pixel_expected[$];
    int   n_in = 0;
    int   n_out = 0;
    int   n_err = 0;
    int   n_cfg = 0;
    int   n_fmt_err = 0;
    bit   calm = 1'b0;

    // value mag * 2**e2 rounded to single, nearest even
    function automatic logic [31:0] round_single(input logic neg, input logic [63:0] mag,
                                                 input int e2);
        int p;
        int sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] hf;
        if (mag == 0) return 32'h0;
        p = 63;
        while (!mag[p]) p--;
        if (p <= 23) begin
            q = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((64'd1 << sh) - 64'd1);
            hf = 64'd1 << (sh - 1);
            q = mag >> sh;
            if (rem > hf || (rem == hf && q[0])) q++;
        end
        return {neg, 31'd0} | ((32'(126 + p + e2) << 23) + q[31:0]);
    endfunction

    // truncate toward zero, magnitudes past 2**62 pinned
    function automatic longint trunc_float(input logic [31:0] b);
        int e;
        longint m;
        e = int'(b[30:23]) - 127;
        if (e < 0) return 0;
        if (e >= 62) return b[31] ? -(64'sd1 <<< 62) : (64'sd1 <<< 62);
        m = longint'({1'b1, b[22:0]});
        m = (e >= 23) ? (m <<< (e - 23)) : (m >>> (23 - e));
        return b[31] ? -m : m;
    endfunction

    function automatic bit is_nan(input logic [31:0] b);
        return b[30:23] == 8'hff && b[22:0] != 0;
    endfunction

    function automatic logic [31:0] sat_int(input logic [31:0] b, input longint lo,
                                            input longint hi);
        longint v;
        if (is_nan(b)) return 32'h0;
        v = trunc_float(b);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v[31:0];
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] s;
        logic [4:0] e;
        logic [10:0] m;
        int ex;
        s = {h[15], 31'd0};
        e = h[14:10];
        m = {1'b0, h[9:0]};
        if (e == 5'h1f) return s | 32'h7f80_0000 | (32'(m) << 13);
        if (e == 0) begin
            if (m == 0) return s;
            ex = 113;
            while (!m[10]) begin
                m = m << 1;
                ex--;
            end
            return s | (32'(ex) << 23) | (32'(m[9:0]) << 13);
        end
        return s | ((32'(e) + 32'd112) << 23) | (32'(m) << 13);
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        logic [15:0] s;
        int e;
        int sh;
        logic [31:0] m;
        logic [31:0] h;
        logic [31:0] rem;
        logic [31:0] hf;
        s = {f[31], 15'd0};
        e = int'(f[30:23]);
        m = {9'd0, f[22:0]};
        if (e == 255) begin
            if (m == 0) return s | 16'h7c00;
            m = m >> 13;
            return s | 16'h7c00 | m[15:0] | ((m == 0) ? 16'd1 : 16'd0);
        end
        e = e - 127 + 15;
        if (e >= 31) return s | 16'h7c00;
        if (e <= 0) begin
            if (e < -10) return s;
            m = m | 32'h0080_0000;
            sh = 14 - e;
            h = m >> sh;
            rem = m & ((32'd1 << sh) - 32'd1);
            hf = 32'd1 << (sh - 1);
        end else begin
            h = (32'(e) << 10) | (m >> 13);
            rem = m & 32'h1fff;
            hf = 32'h1000;
        end
        if (rem > hf || (rem == hf && h[0])) h++;
        return s | h[15:0];
    endfunction

    // normalized code to float: quotient mag/d rounded once to single
    function automatic logic [31:0] norm_to_single(input logic neg, input logic [31:0] mag,
                                                   input logic [31:0] d);
        logic [63:0] num;
        logic [63:0] q0;
        logic [63:0] r;
        if (mag == 0) return 32'h0;
        if (neg && mag > d) return NEG_ONE_BITS;
        num = 64'(mag) << 40;
        q0 = num / 64'(d);
        r = num % 64'(d);
        return round_single(neg, (q0 << 1) | 64'(r != 0), -41);
    endfunction

    // clamp, scale by k in single precision, truncate
    function automatic logic [31:0] single_to_norm(input logic [31:0] b, input bit sgn,
                                                   input logic [31:0] k);
        logic [31:0] pb;
        longint v;
        if (is_nan(b)) return 32'h0;
        if (!sgn && b[31]) return 32'h0;
        if (b[30:0] >= pfc_pkg::ONE_BITS) v = b[31] ? -longint'(k) : longint'(k);
        else if (b[30:23] == 0) v = 0;
        else begin
            pb = round_single(b[31], 64'({1'b1, b[22:0]}) * 64'(k), int'(b[30:23]) - 150);
            v = trunc_float(pb);
        end
        return v[31:0] & (sgn ? (k == 32'd127 ? 32'hff : 32'hffff) : 32'hffff_ffff);
    endfunction

    function automatic logic [31:0] unpack_comp(input logic [31:0] raw);
        int w;
        bit sgn;
        logic [31:0] v;
        logic [31:0] wmask;
        logic neg;
        logic [31:0] mag;
        logic [31:0] d;
        if (cvt_elem == pfc_pkg::ET_HALF) return half_to_single(raw[15:0]);
        if (cvt_elem == pfc_pkg::ET_F32) return raw;
        w = (cvt_elem inside {pfc_pkg::ET_U8, pfc_pkg::ET_S8}) ? 8 :
            ((cvt_elem inside {pfc_pkg::ET_U16, pfc_pkg::ET_S16}) ? 16 : 32);
        sgn = cvt_elem inside {pfc_pkg::ET_S8, pfc_pkg::ET_S16, pfc_pkg::ET_S32};
        wmask = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
        v = raw & wmask;
        neg = sgn && v[w-1];
        mag = neg ? ((~v + 32'd1) & wmask) : v;
        if (cvt_norm) begin
            case (cvt_elem)
                pfc_pkg::ET_U8:  d = 32'd255;
                pfc_pkg::ET_S8:  d = 32'd127;
                pfc_pkg::ET_U16: d = 32'd65535;
                default:         d = 32'd32767;
            endcase
            return norm_to_single(neg, mag, d);
        end
        return round_single(neg, 64'(mag), 0);
    endfunction

    function automatic logic [31:0] pack_comp(input logic [31:0] fb);
        if (cvt_elem == pfc_pkg::ET_HALF) return 32'(single_to_half(fb));
        if (cvt_elem == pfc_pkg::ET_F32) return fb;
        if (cvt_norm) begin
            case (cvt_elem)
                pfc_pkg::ET_U8:  return single_to_norm(fb, 1'b0, 32'd255);
                pfc_pkg::ET_S8:  return single_to_norm(fb, 1'b1, 32'd127);
                pfc_pkg::ET_U16: return single_to_norm(fb, 1'b0, 32'd65535);
                default:         return single_to_norm(fb, 1'b1, 32'd32767);
            endcase
        end
        case (cvt_elem)
            pfc_pkg::ET_U8:  return sat_int(fb, 0, 255);
            pfc_pkg::ET_S8:  return sat_int(fb, -128, 127) & 32'hff;
            pfc_pkg::ET_U16: return sat_int(fb, 0, 65535);
            pfc_pkg::ET_S16: return sat_int(fb, -32768, 32767) & 32'hffff;
            pfc_pkg::ET_U32: return sat_int(fb, 0, 64'sd4294967295);
            default:         return sat_int(fb, -64'sd2147483648, 64'sd2147483647);
        endcase
    endfunction

    function automatic pfc_pkg::t_out convert_pixel(input pfc_pkg::t_in x);
        pfc_pkg::t_out r;
        logic [31:0] fo[4];
        logic [31:0] ro[4];
        logic [31:0] ri[4];
        logic [31:0] fi[4];
        int n;
        r = '0;
        if (cvt_norm && cvt_elem inside {pfc_pkg::ET_U32, pfc_pkg::ET_S32,
                                         pfc_pkg::ET_HALF, pfc_pkg::ET_F32}) begin
            r.format_error = 1'b1;
            return r;
        end
        n = (cvt_count > 3'd4) ? 4 : int'(cvt_count);
        ri = '{x.raw_in_0, x.raw_in_1, x.raw_in_2, x.raw_in_3};
        fi = '{x.float_in_0, x.float_in_1, x.float_in_2, x.float_in_3};
        fo = '{32'h0, 32'h0, 32'h0,
               (x.mode == pfc_pkg::MODE_PACK) ? 32'h0 : pfc_pkg::ONE_BITS};
        ro = '{32'h0, 32'h0, 32'h0, 32'h0};
        for (int i = 0; i < n; i++) begin
            if (x.mode == pfc_pkg::MODE_PACK) ro[i] = pack_comp(fi[i]);
            else fo[i] = unpack_comp(ri[i]);
        end
        r.float_out_0 = fo[0];
        r.float_out_1 = fo[1];
        r.float_out_2 = fo[2];
        r.float_out_3 = fo[3];
        r.raw_out_0 = ro[0];
        r.raw_out_1 = ro[1];
        r.raw_out_2 = ro[2];
        r.raw_out_3 = ro[3];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d field %s: got %h expected %h", n_out, field, got, want);
        n_err++;
    endtask

    task automatic check_result(input pfc_pkg::t_out got, input pfc_pkg::t_out want);
        if (got.float_out_0 !== want.float_out_0)
            report_mismatch("float_out_0", got.float_out_0, want.float_out_0);
        if (got.float_out_1 !== want.float_out_1)
            report_mismatch("float_out_1", got.float_out_1, want.float_out_1);
        if (got.float_out_2 !== want.float_out_2)
            report_mismatch("float_out_2", got.float_out_2, want.float_out_2);
        if (got.float_out_3 !== want.float_out_3)
            report_mismatch("float_out_3", got.float_out_3, want.float_out_3);
        if (got.raw_out_0 !== want.raw_out_0)
            report_mismatch("raw_out_0", got.raw_out_0, want.raw_out_0);
        if (got.raw_out_1 !== want.raw_out_1)
            report_mismatch("raw_out_1", got.raw_out_1, want.raw_out_1);
        if (got.raw_out_2 !== want.raw_out_2)
            report_mismatch("raw_out_2", got.raw_out_2, want.raw_out_2);
        if (got.raw_out_3 !== want.raw_out_3)
            report_mismatch("raw_out_3", got.raw_out_3, want.raw_out_3);
        if (got.format_error !== want.format_error)
            report_mismatch("format_error", 32'(got.format_error), 32'(want.format_error));
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 2);
        return $urandom_range(5, 30);
    endfunction

    // input driver
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                pixel_expected.push_back(convert_pixel(i_in));
                n_in++;
            end
            if (i_valid && o_stall) begin
                // hold the stalled transaction
            end else if (gap > 0) begin
                gap <= gap - 1;
                i_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                i_in <= pixel_queue.pop_front();
                i_valid <= 1'b1;
                gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    int hold_left = 0;
    int mood_cnt = 0;
    bit long_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pixel_expected.size() == 0) begin
                    $display("unexpected result transaction %0d", n_out);
                    n_err++;
                end else begin
                    check_result(o_out, pixel_expected.pop_front());
                end
                n_out++;
            end
            mood_cnt++;
            if (mood_cnt % 97 == 0) calm = ($urandom_range(0, 3) == 0);
            if (!long_done && n_out >= LONG_HOLD_AT) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD_LEN;
            end else if (hold_left == 0 && !calm && $urandom_range(0, 299) == 0) begin
                hold_left = $urandom_range(20, 60);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 9) < 3);
            end
        end
    end

    // watchdog on cycles with no transaction
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pixel_expected.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [2:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            pfc_pkg::CFG_ELEM:  cvt_elem = pfc_pkg::t_elem'(data);
            pfc_pkg::CFG_NORM:  cvt_norm = data[0];
            pfc_pkg::CFG_COUNT: cvt_count = data;
            default: ;
        endcase
    endtask

    // wait until the converter has drained, sampled after the edge settles
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pixel_queue.size() > 0 || i_valid || pixel_expected.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_format(input int e, input bit nrm, input int cnt);
        drain();
        if (nrm && e >= 4) n_fmt_err++;
        cfg_write(pfc_pkg::CFG_ELEM, 3'(e));
        cfg_write(pfc_pkg::CFG_NORM, {2'($urandom_range(0, 3)), nrm});
        cfg_write(pfc_pkg::CFG_COUNT, 3'(cnt));
    endtask

    function automatic logic [31:0] rand_raw();
        logic [31:0] sp[19] = '{32'h0, 32'hff, 32'h7f, 32'h80, 32'h81, 32'hffff, 32'h7fff,
                                32'h8000, 32'h8001, 32'h7c00, 32'hfc00, 32'h7e01, 32'h3c00,
                                32'h1, 32'h3ff, 32'h400, 32'h8000_0000, 32'h7fff_ffff,
                                32'hffff_ffff};
        case ($urandom_range(0, 3))
            0: return sp[$urandom_range(0, 18)];
            1: return sp[$urandom_range(0, 15)] | ($urandom & 32'hffff_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] sp[23] = '{32'h0, 32'h8000_0000, pfc_pkg::ONE_BITS, NEG_ONE_BITS,
                                32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001,
                                32'hffc0_0123, 32'h3f00_0000, 32'h477f_ff00, 32'h477f_e000,
                                32'h4f80_0000, 32'hcf00_0000, 32'h4b7f_ffff, 32'h0000_0001,
                                32'h3380_0000, 32'h3880_0000, 32'h387f_c000, 32'hc300_0000,
                                32'h437f_0000, 32'h3f7f_ffff, 32'hbf80_0001};
        case ($urandom_range(0, 4))
            0: return sp[$urandom_range(0, 22)];
            1: return $urandom;
            default: return round_single(1'($urandom_range(0, 1)),
                                         64'($urandom_range(0, 1 << 20)),
                                         -$urandom_range(0, 24));
        endcase
    endfunction

    function automatic pfc_pkg::t_in rand_pixel();
        pfc_pkg::t_in x;
        x.mode = 1'($urandom_range(0, 1));
        x.raw_in_0 = rand_raw();
        x.raw_in_1 = rand_raw();
        x.raw_in_2 = rand_raw();
        x.raw_in_3 = rand_raw();
        x.float_in_0 = rand_float();
        x.float_in_1 = rand_float();
        x.float_in_2 = rand_float();
        x.float_in_3 = rand_float();
        return x;
    endfunction

    // directed pair: extreme codes unpacked, special floats packed
    task automatic push_directed();
        pfc_pkg::t_in x;
        x = '{pfc_pkg::MODE_UNPACK, 32'h0, 32'hffff_ffff, 32'h0000_8080, 32'h8000_7c00,
              32'h7fc0_0000, 32'hff80_0000, pfc_pkg::ONE_BITS, 32'h4f80_0000};
        pixel_queue.push_back(x);
        x = '{pfc_pkg::MODE_PACK, 32'h7fff_ff7f, 32'h8000_0001, 32'h1234_8000, 32'hffff_fffe,
              32'h7fc0_0000, 32'hff80_0000, NEG_ONE_BITS, 32'h4f80_0000};
        pixel_queue.push_back(x);
    endtask

    initial begin
        int dir_cfg[11][3] = '{'{1, 1, 4}, '{2, 1, 4}, '{3, 1, 3}, '{4, 0, 4}, '{5, 0, 2},
                                '{6, 0, 4}, '{7, 0, 4}, '{1, 0, 4}, '{3, 0, 1}, '{4, 1, 4},
                                '{0, 0, 0}};
        int fix_cfg[4][3] = '{'{0, 1, 1}, '{7, 0, 4}, '{3, 1, 0}, '{5, 0, 7}};
        int e;
        int cnt;
        bit nrm;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset format first, then a directed pair per format
        push_directed();
        foreach (dir_cfg[k]) begin
            set_format(dir_cfg[k][0], 1'(dir_cfg[k][1]), dir_cfg[k][2]);
            push_directed();
        end

        // random phases, each with its own format
        for (int ph = 0; ph < 15; ph++) begin
            if (ph < 4) begin
                e = fix_cfg[ph][0];
                nrm = 1'(fix_cfg[ph][1]);
                cnt = fix_cfg[ph][2];
            end else begin
                e = $urandom_range(0, 7);
                nrm = (e < 4) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            end
            set_format(e, nrm, cnt);
            for (int i = 0; i < 40; i++) pixel_queue.push_back(rand_pixel());
        end
        drain();
        repeat (10) @(posedge i_clk);

        $display("covered %0d pixels in %0d results over %0d register writes", n_in, n_out, n_cfg);
        $display("all eight element formats, both modes, %0d format-error settings", n_fmt_err);
        if (n_err == 0 && pixel_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", n_err, pixel_expected.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_lane.sv
hdl/pixel_component_format_converter_top.sv
sim/tb_pixel_component_format_converter_top.sv
